>>> rtl/gfr_pkg.sv
// Shared widths of the GF(2) matrix rank block's ports and register.
`default_nettype none
package gfr_pkg;

	// width of one reduced row on the output
	localparam int unsigned ROW_W = 64;
	// width of the rank on the output
	localparam int unsigned RANK_W = 7;
	// width of the column_count register
	localparam int unsigned COLS_W = 7;
	// output tdata: reduced_row, rank_value, padded to whole bytes
	localparam int unsigned OUT_DATA_W = ((ROW_W + RANK_W + 7) / 8) * 8;
	// input tdata: row_bits
	localparam int unsigned IN_DATA_W = ROW_W;
	// reset value of column_count
	localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;

endpackage
`default_nettype wire

>>> rtl/gf2_matrix_rank.sv
// Rank and reduced row-echelon form over GF(2) of a streamed binary matrix.
//
// Input channel (s_*): one matrix row per beat, bit c of s_tdata is column c; s_tlast
// marks the final row and starts elimination. Rows load at one per cycle. Rows past
// MAX_ROWS are dropped and flagged; bits at and above ROW_BITS are ignored.
// Output channel (m_*): every stored row of the reduced matrix in row order, with the
// rank in tdata and the overflow flag in tuser; m_tlast marks the last row.
// Config channel (cfg_*): column_count, always ready; write it only while idle.
// The row store is a single-port-write, single-read memory, so elimination is
// sequenced one memory row per step. Each pivot column takes a check step, a read and a
// check step per row scanned for the pivot, a read and two writes for a swap, and for the
// XOR pass a read and a write per row other than the pivot row; a column with no pivot
// ends after its scan. Emission fetches the first row, then gives one beat per row.
// s_tready is low from the last row until the final output beat is taken.
// A stalled receiver simply holds the current output beat; the sequencer waits.
// Reset (arst_n low) empties the store, clears the overflow flag and sets
// column_count to 64; no clearing pass is needed.
`default_nettype none
module gf2_matrix_rank #(
	parameter int unsigned MAX_ROWS = 64,
	parameter int unsigned ROW_BITS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// row input
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [gfr_pkg::IN_DATA_W-1:0]     s_tdata,   // [63:0] row_bits
	input  wire logic                              s_tlast,   // last_row
	// reduced rows out
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [gfr_pkg::OUT_DATA_W-1:0]         m_tdata,   // [63:0] reduced_row,
	                                                          // [70:64] rank_value, [71] 0
	output logic                                   m_tuser,   // rows_dropped
	output logic                                   m_tlast,   // final_result
	// column_count write
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [gfr_pkg::COLS_W-1:0]        cfg_data
);

	localparam int unsigned AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned CW  = $clog2(MAX_ROWS + 1);
	localparam int unsigned CIW = (ROW_BITS > 1) ? $clog2(ROW_BITS) : 1;
	localparam int unsigned CLW = $clog2(ROW_BITS + 1);
	localparam logic [gfr_pkg::COLS_W-1:0] ROW_BITS_C = gfr_pkg::COLS_W'(ROW_BITS);
	localparam logic [CW-1:0] MAX_ROWS_C = CW'(MAX_ROWS);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_COL_CHECK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SWAP_RD,
		ST_SWAP_W1,
		ST_SWAP_W2,
		ST_XOR_RD,
		ST_XOR_WR,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	state_t               state_q;
	logic [gfr_pkg::COLS_W-1:0] cols_cfg_q;
	logic [CW-1:0]        cnt_q;
	logic                 ovf_q;
	logic [CW-1:0]        rank_q;
	logic [CLW-1:0]       col_q;
	logic [CLW-1:0]       ncols_q;
	logic [CW-1:0]        ptr_q;
	logic [CW-1:0]        piv_idx_q;
	logic [ROW_BITS-1:0]  piv_row_q;

	// row store
	logic [ROW_BITS-1:0]  mem [MAX_ROWS];
	logic [ROW_BITS-1:0]  rd_data_q;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [ROW_BITS-1:0]  wr_data;

	logic                 in_beat;
	logic                 out_beat;
	logic [CW-1:0]        ptr_inc;
	logic                 ptr_at_end;
	logic                 pivot_bit;
	logic [CLW-1:0]       ncols_lim;

	assign in_beat    = s_tvalid && s_tready;
	assign out_beat   = m_tvalid && m_tready;
	assign ptr_inc    = ptr_q + CW'(1);
	assign ptr_at_end = (ptr_inc == cnt_q);
	assign pivot_bit  = rd_data_q[col_q[CIW-1:0]];
	assign ncols_lim  = (cols_cfg_q > ROW_BITS_C) ? CLW'(ROW_BITS) : CLW'(cols_cfg_q);

	// handshake and output fields
	assign s_tready  = (state_q == ST_LOAD);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = (state_q == ST_EMIT_OUT);
	assign m_tdata   = {1'b0, gfr_pkg::RANK_W'(rank_q), gfr_pkg::ROW_W'(rd_data_q)};
	assign m_tuser   = ovf_q;
	assign m_tlast   = ptr_at_end;

	// memory read port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q[AW-1:0];
		unique case (state_q)
			ST_SCAN_RD, ST_EMIT_RD: begin
				rd_en = 1'b1;
			end
			ST_SWAP_RD: begin
				rd_en   = 1'b1;
				rd_addr = rank_q[AW-1:0];
			end
			ST_XOR_RD: begin
				rd_en = (ptr_q != rank_q);
			end
			ST_EMIT_OUT: begin
				rd_en   = out_beat && !ptr_at_end;
				rd_addr = ptr_inc[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// memory write port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q[AW-1:0];
		wr_data = rd_data_q ^ piv_row_q;
		unique case (state_q)
			ST_LOAD: begin
				wr_en   = in_beat && (cnt_q < MAX_ROWS_C);
				wr_addr = cnt_q[AW-1:0];
				wr_data = s_tdata[ROW_BITS-1:0];
			end
			ST_SWAP_W1: begin
				wr_en   = 1'b1;
				wr_addr = piv_idx_q[AW-1:0];
				wr_data = rd_data_q;
			end
			ST_SWAP_W2: begin
				wr_en   = 1'b1;
				wr_addr = rank_q[AW-1:0];
				wr_data = piv_row_q;
			end
			ST_XOR_WR: begin
				wr_en = pivot_bit;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// row store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// column_count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= gfr_pkg::COLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cols_cfg_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			rank_q    <= '0;
			col_q     <= '0;
			ncols_q   <= '0;
			ptr_q     <= '0;
			piv_idx_q <= '0;
		end else begin
			unique case (state_q)
				// collect rows until the last one
				ST_LOAD: begin
					if (in_beat) begin
						if (cnt_q < MAX_ROWS_C) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							rank_q  <= '0;
							col_q   <= '0;
							ncols_q <= ncols_lim;
							state_q <= ST_COL_CHECK;
						end
					end
				end
				// next pivot column or done
				ST_COL_CHECK: begin
					if ((col_q < ncols_q) && (rank_q < cnt_q)) begin
						ptr_q   <= rank_q;
						state_q <= ST_SCAN_RD;
					end else begin
						ptr_q   <= '0;
						state_q <= ST_EMIT_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				// pivot search from the rank row down
				ST_SCAN_CHK: begin
					if (pivot_bit) begin
						piv_row_q <= rd_data_q;
						piv_idx_q <= ptr_q;
						if (ptr_q == rank_q) begin
							ptr_q   <= '0;
							state_q <= ST_XOR_RD;
						end else begin
							state_q <= ST_SWAP_RD;
						end
					end else if (ptr_at_end) begin
						col_q   <= col_q + CLW'(1);
						state_q <= ST_COL_CHECK;
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= ST_SCAN_RD;
					end
				end
				// swap pivot row into the rank slot
				ST_SWAP_RD: begin
					state_q <= ST_SWAP_W1;
				end
				ST_SWAP_W1: begin
					state_q <= ST_SWAP_W2;
				end
				ST_SWAP_W2: begin
					ptr_q   <= '0;
					state_q <= ST_XOR_RD;
				end
				// clear the pivot column in every other row
				ST_XOR_RD: begin
					if (ptr_q != rank_q) begin
						state_q <= ST_XOR_WR;
					end else if (ptr_at_end) begin
						rank_q  <= rank_q + CW'(1);
						col_q   <= col_q + CLW'(1);
						state_q <= ST_COL_CHECK;
					end else begin
						ptr_q <= ptr_inc;
					end
				end
				ST_XOR_WR: begin
					if (ptr_at_end) begin
						rank_q  <= rank_q + CW'(1);
						col_q   <= col_q + CLW'(1);
						state_q <= ST_COL_CHECK;
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= ST_XOR_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_OUT;
				end
				// one beat per row; next row fetched as the beat goes
				ST_EMIT_OUT: begin
					if (out_beat) begin
						if (ptr_at_end) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							ptr_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							ptr_q <= ptr_inc;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
